>>> src/ryc_pkg.sv
// ryc_pkg: shared types and constants for the RGB / YPbPr color converter.
// Pixel and result word structs, opcodes, register index, Q1.15 coefficients.
// No dependencies.
package ryc_pkg;

	localparam int FRAC_BITS = 15;
	localparam int DIV_STEPS = 16;
	localparam int LATENCY   = DIV_STEPS + 5;

	typedef enum logic {
		OP_FWD = 1'b0,
		OP_INV = 1'b1
	} ryc_op_t;

	localparam logic REG_DEN = 1'b0;
	localparam logic [15:0] DEN_RESET = 16'd255;

	localparam logic [15:0] Y_HI = 16'(2 ** FRAC_BITS);
	localparam logic signed [15:0] C_HI = 16'(2 ** (FRAC_BITS - 1));
	localparam logic signed [15:0] C_LO = -C_HI;

	function automatic logic [15:0] fx_coef(input longint unsigned ppm);
		return 16'(((ppm << FRAC_BITS) + 64'd500000) / 64'd1000000);
	endfunction

	localparam logic [15:0] CF_YR = fx_coef(299000);
	localparam logic [15:0] CF_YG = fx_coef(587000);
	localparam logic [15:0] CF_YB = fx_coef(114000);
	localparam logic [15:0] CF_BR = fx_coef(168736);
	localparam logic [15:0] CF_BG = fx_coef(331264);
	localparam logic [15:0] CF_HF = fx_coef(500000);
	localparam logic [15:0] CF_RG = fx_coef(418688);
	localparam logic [15:0] CF_RB = fx_coef(81312);
	localparam logic [15:0] CF_RV = fx_coef(1402000);
	localparam logic [15:0] CF_GU = fx_coef(344136);
	localparam logic [15:0] CF_GV = fx_coef(714136);
	localparam logic [15:0] CF_BU = fx_coef(1772000);

	typedef struct packed {
		ryc_op_t            opcode;
		logic [15:0]        red_in;
		logic [15:0]        green_in;
		logic [15:0]        blue_in;
		logic [15:0]        luma_in;
		logic signed [15:0] pb_in;
		logic signed [15:0] pr_in;
	} ryc_in_t;

	typedef struct packed {
		logic [15:0]        luma_out;
		logic signed [15:0] pb_out;
		logic signed [15:0] pr_out;
		logic [7:0]         red_out;
		logic [7:0]         green_out;
		logic [7:0]         blue_out;
	} ryc_out_t;

endpackage

>>> src/rgb_ypbpr_color_converter_unit.sv
// rgb_ypbpr_color_converter_unit: pipelined BT.601 RGB <-> YPbPr converter.
// Constant multiply, sum, scale, 16-step restoring divider, clamp.
// Depends on ryc_pkg.

// Takes one pixel word per clock; busy never rises. Each accepted word gives
// one result word, flagged by done, in order. The word passes stages s1 to
// s4, the 16-stage restoring divider of the forward path (one quotient bit
// per stage) and the output register; inverse words ride along in
// the same stages to keep order. The denominator register should only be
// written while no word is in flight. There is no flow control on results.
module rgb_ypbpr_color_converter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:2]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                start,
	output logic                busy,
	input  ryc_pkg::ryc_in_t    pixel,
	output logic                done,
	output ryc_pkg::ryc_out_t   result
);

	typedef struct packed {
		logic             fwd;
		logic [2:0]       neg;
		logic [2:0]       ovf;
		logic [2:0][32:0] rem;
		logic [2:0][15:0] quo;
		logic [2:0][7:0]  rgb;
	} dv_t;

	function automatic logic signed [33:0] mul_u(input logic [15:0] a, input logic [15:0] c);
		return signed'({18'd0, a}) * signed'({18'd0, c});
	endfunction

	function automatic logic signed [33:0] mul_s(input logic [15:0] a, input logic [15:0] c);
		return signed'({{18{a[15]}}, a}) * signed'({18'd0, c});
	endfunction

	logic [15:0] den_q;
	logic [15:0] d_eff;
	logic [32:0] dshift;

	logic                v_s1, v_s2, v_s3;
	logic                fwd_s1, fwd_s2, fwd_s3;
	logic signed [33:0]  fp_s1 [0:2][0:2];
	logic signed [33:0]  ip_s1 [0:3];
	logic signed [33:0]  yw_s1;
	logic signed [33:0]  fs_s2 [0:2];
	logic signed [33:0]  is_s2 [0:2];
	logic [2:0]          neg_s3;
	logic [32:0]         n_s3 [0:2];
	logic [2:0]          pos_s3;
	logic [48:0]         ipr_s3 [0:2];

	dv_t  dv_s [0:ryc_pkg::DIV_STEPS];
	logic dv_v_s [0:ryc_pkg::DIV_STEPS];

	logic              done_q;
	ryc_pkg::ryc_out_t result_q;
	ryc_pkg::ryc_out_t res_d;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr == ryc_pkg::REG_DEN) ? {16'd0, den_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q <= ryc_pkg::DEN_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ryc_pkg::REG_DEN) begin
			den_q <= pwdata[15:0];
		end
	end

	assign d_eff  = (den_q == 16'd0) ? 16'd1 : den_q;
	assign dshift = {d_eff, 1'b0, 16'd0};
	assign busy   = 1'b0;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int k = 0; k <= ryc_pkg::DIV_STEPS; k++) begin
				dv_v_s[k] <= 1'b0;
			end
			done_q <= 1'b0;
		end else begin
			v_s1      <= start && !busy;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			dv_v_s[0] <= v_s3;
			for (int k = 1; k <= ryc_pkg::DIV_STEPS; k++) begin
				dv_v_s[k] <= dv_v_s[k-1];
			end
			done_q <= dv_v_s[ryc_pkg::DIV_STEPS];
		end
	end

	// s1: constant products
	always_ff @(posedge clk) begin
		fwd_s1      <= (pixel.opcode == ryc_pkg::OP_FWD);
		fp_s1[0][0] <= mul_u(pixel.red_in,   ryc_pkg::CF_YR);
		fp_s1[0][1] <= mul_u(pixel.green_in, ryc_pkg::CF_YG);
		fp_s1[0][2] <= mul_u(pixel.blue_in,  ryc_pkg::CF_YB);
		fp_s1[1][0] <= mul_u(pixel.red_in,   ryc_pkg::CF_BR);
		fp_s1[1][1] <= mul_u(pixel.green_in, ryc_pkg::CF_BG);
		fp_s1[1][2] <= mul_u(pixel.blue_in,  ryc_pkg::CF_HF);
		fp_s1[2][0] <= mul_u(pixel.red_in,   ryc_pkg::CF_HF);
		fp_s1[2][1] <= mul_u(pixel.green_in, ryc_pkg::CF_RG);
		fp_s1[2][2] <= mul_u(pixel.blue_in,  ryc_pkg::CF_RB);
		ip_s1[0]    <= mul_s(pixel.pr_in, ryc_pkg::CF_RV);
		ip_s1[1]    <= mul_s(pixel.pb_in, ryc_pkg::CF_GU);
		ip_s1[2]    <= mul_s(pixel.pr_in, ryc_pkg::CF_GV);
		ip_s1[3]    <= mul_s(pixel.pb_in, ryc_pkg::CF_BU);
		yw_s1       <= signed'(34'(pixel.luma_in) << ryc_pkg::FRAC_BITS);
	end

	// s2: sums
	always_ff @(posedge clk) begin
		fwd_s2   <= fwd_s1;
		fs_s2[0] <= fp_s1[0][0] + fp_s1[0][1] + fp_s1[0][2];
		fs_s2[1] <= fp_s1[1][2] - fp_s1[1][0] - fp_s1[1][1];
		fs_s2[2] <= fp_s1[2][0] - fp_s1[2][1] - fp_s1[2][2];
		is_s2[0] <= yw_s1 + ip_s1[0];
		is_s2[1] <= yw_s1 - ip_s1[1] - ip_s1[2];
		is_s2[2] <= yw_s1 + ip_s1[3];
	end

	// s3: forward rounding numerator, inverse scale by denominator
	always_ff @(posedge clk) begin
		logic signed [33:0] mag;
		fwd_s3 <= fwd_s2;
		for (int c = 0; c < 3; c++) begin
			mag        = fs_s2[c][33] ? -fs_s2[c] : fs_s2[c];
			neg_s3[c]  <= fs_s2[c][33];
			n_s3[c]    <= {mag[31:0], 1'b0} + 33'(d_eff);
			pos_s3[c]  <= !is_s2[c][33] && (is_s2[c] != 34'sd0);
			ipr_s3[c]  <= 49'(is_s2[c][32:0]) * 49'(d_eff);
		end
	end

	// s4: divider entry, inverse round and clamp
	always_ff @(posedge clk) begin
		logic [49:0] t;
		dv_s[0].fwd <= fwd_s3;
		dv_s[0].neg <= neg_s3;
		for (int c = 0; c < 3; c++) begin
			t                  = 50'(ipr_s3[c]) + (50'd1 << (2 * ryc_pkg::FRAC_BITS - 1));
			dv_s[0].ovf[c]     <= (n_s3[c] >= dshift);
			dv_s[0].rem[c]     <= n_s3[c];
			dv_s[0].quo[c]     <= 16'd0;
			if (!pos_s3[c]) begin
				dv_s[0].rgb[c] <= 8'd0;
			end else if (|t[49:2*ryc_pkg::FRAC_BITS+8]) begin
				dv_s[0].rgb[c] <= 8'hFF;
			end else begin
				dv_s[0].rgb[c] <= t[2*ryc_pkg::FRAC_BITS +: 8];
			end
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < ryc_pkg::DIV_STEPS; k++) begin : g_div
		logic [32:0] cmp;
		assign cmp = dshift >> (k + 1);

		always_ff @(posedge clk) begin
			dv_s[k+1].fwd <= dv_s[k].fwd;
			dv_s[k+1].neg <= dv_s[k].neg;
			dv_s[k+1].ovf <= dv_s[k].ovf;
			dv_s[k+1].rgb <= dv_s[k].rgb;
			for (int c = 0; c < 3; c++) begin
				if (dv_s[k].rem[c] >= cmp) begin
					dv_s[k+1].rem[c] <= dv_s[k].rem[c] - cmp;
					dv_s[k+1].quo[c] <= dv_s[k].quo[c] | (16'd1 << (ryc_pkg::DIV_STEPS - 1 - k));
				end else begin
					dv_s[k+1].rem[c] <= dv_s[k].rem[c];
					dv_s[k+1].quo[c] <= dv_s[k].quo[c];
				end
			end
		end
	end

	// output saturation (forward path; inverse bytes pass through)
	always_comb begin
		dv_t         f;
		logic [15:0] cmag;
		f     = dv_s[ryc_pkg::DIV_STEPS];
		res_d = '0;
		cmag  = '0;
		if (f.fwd) begin
			if (f.neg[0]) begin
				res_d.luma_out = 16'd0;
			end else if (f.ovf[0] || f.quo[0] > ryc_pkg::Y_HI) begin
				res_d.luma_out = ryc_pkg::Y_HI;
			end else begin
				res_d.luma_out = f.quo[0];
			end
			cmag = (f.ovf[1] || f.quo[1] > ryc_pkg::C_HI) ? ryc_pkg::C_HI : f.quo[1];
			res_d.pb_out = f.neg[1] ? -signed'(cmag) : signed'(cmag);
			cmag = (f.ovf[2] || f.quo[2] > ryc_pkg::C_HI) ? ryc_pkg::C_HI : f.quo[2];
			res_d.pr_out = f.neg[2] ? -signed'(cmag) : signed'(cmag);
		end else begin
			res_d.red_out   = f.rgb[0];
			res_d.green_out = f.rgb[1];
			res_d.blue_out  = f.rgb[2];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, ryc_pkg::LATENCY))
		else $error("result word without matching start");

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(ryc_pkg::LATENCY) done)
		else $error("accepted word lost in pipeline");

	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.red_out == 8'd0 && result.green_out == 8'd0 && result.blue_out == 8'd0)
			|| (result.luma_out == 16'd0 && result.pb_out == 16'sd0 && result.pr_out == 16'sd0))
		else $error("result mixes forward and inverse fields");

	a_fwd_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.luma_out <= ryc_pkg::Y_HI
			&& result.pb_out >= ryc_pkg::C_LO && result.pb_out <= ryc_pkg::C_HI
			&& result.pr_out >= ryc_pkg::C_LO && result.pr_out <= ryc_pkg::C_HI)
		else $error("forward result out of range");

endmodule
